// ===== hdl/ssq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and codes for the sorted sleep and wake queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int KEY_W      = 64;
    localparam int ID_W       = 8;
    localparam int TICK_W     = 63;
    localparam int DUR_W      = 32;
    localparam int RESULT_CAP = 16;
    localparam int POP_W      = $clog2(RESULT_CAP);

    typedef enum logic [2:0] {
        KIND_QUEUED   = 3'd0,
        KIND_IGNORED  = 3'd1,
        KIND_REJECTED = 3'd2,
        KIND_NONE_DUE = 3'd3,
        KIND_WOKEN    = 3'd4
    } kind_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_SLEEP = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WAKE = 1'b1
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } ctrl_t;

endpackage

// ===== hdl/ssq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: holds a wake tick and thread id, opens for
// an insert, and moves its entry up or down the chain with its neighbors.
// ----------------------------------------------------------------------------
module ssq_cell
(
    input  logic            clk,
    input  ssq_pkg::ctrl_t  ctrl,
    input  logic            occupied,
    input  ssq_pkg::entry_t new_entry,
    input  logic            prev_open,
    input  ssq_pkg::entry_t prev_entry,
    input  ssq_pkg::entry_t next_entry,
    output logic            open,
    output ssq_pkg::entry_t entry
);

    ssq_pkg::entry_t entry_reg;
    ssq_pkg::entry_t entry_next;

    assign open  = !occupied || (entry_reg.key > new_entry.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && open)
        begin
            entry_next = prev_open ? prev_entry : new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/sorted_sleep_wake_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sleep_wake_queue_unit
// Tick counter with a sorted chain of sleeping threads ordered by wake tick.
// ----------------------------------------------------------------------------
// For a sleep request every cell compares its wake tick with the new one in
// parallel, and the chain shifts open at the insert point in that cycle,
// while its single result is written to the output register. A tick first
// advances the counter; then, whenever the output is free, the front cell
// is checked, popped and the chain shifts forward, one result each time, so
// a tick wakes at most sixteen threads, and one that wakes none still gives
// one result. The next input is taken once the last result of the current
// one is in the output register and the output is not stalled.
// ----------------------------------------------------------------------------
module sorted_sleep_wake_queue_unit
#(
    parameter int MAX_SLEEPERS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [ssq_pkg::ID_W-1:0]      thread_id,
    input  logic signed [ssq_pkg::DUR_W-1:0] duration,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    kind,
    output logic [ssq_pkg::ID_W-1:0]      woken_id,
    output logic [ssq_pkg::TICK_W-1:0]    now_tick,
    output logic                          last
);

    localparam int OCC_W = $clog2(MAX_SLEEPERS + 1);

    ssq_pkg::state_t                 state_reg, state_next;
    logic [ssq_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [OCC_W-1:0]                occ_reg, occ_next;
    logic [ssq_pkg::POP_W-1:0]       pop_cnt_reg, pop_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    ssq_pkg::kind_t                  kind_reg, kind_next;
    logic [ssq_pkg::ID_W-1:0]        id_reg, id_next;
    logic [ssq_pkg::TICK_W-1:0]      now_reg, now_next;
    logic                            last_reg, last_next;

    ssq_pkg::ctrl_t                  ctrl;
    ssq_pkg::entry_t                 new_entry;
    ssq_pkg::entry_t                 cell_entry [MAX_SLEEPERS];
    logic                            cell_open  [MAX_SLEEPERS];

    logic                            accept;
    logic                            out_free;
    logic                            dur_positive;
    logic                            full;
    logic                            front_due;
    logic                            second_due;
    logic                            pop_last;
    logic [ssq_pkg::KEY_W-1:0]       tick_wide;

    assign out_free     = !out_valid_reg || !out_stall;
    assign in_stall     = (state_reg != ssq_pkg::ST_IDLE) || !out_free;
    assign accept       = in_valid && !in_stall;
    assign dur_positive = !duration[ssq_pkg::DUR_W-1] && (duration != '0);
    assign full         = (occ_reg == OCC_W'(MAX_SLEEPERS));
    assign tick_wide    = ssq_pkg::KEY_W'(tick_reg);

    assign new_entry.key = ssq_pkg::KEY_W'(tick_reg) + ssq_pkg::KEY_W'($unsigned(duration));
    assign new_entry.id  = thread_id;

    assign front_due  = (occ_reg != '0) && (cell_entry[0].key <= tick_wide);
    assign second_due = (occ_reg > OCC_W'(1)) && (cell_entry[1].key <= tick_wide);
    assign pop_last   = (pop_cnt_reg == ssq_pkg::POP_W'(ssq_pkg::RESULT_CAP - 1))
                        || !second_due;

    genvar i;
    generate
        for (i = 0; i < MAX_SLEEPERS; i++)
        begin : g_cell
            logic            occupied;
            logic            prev_open;
            ssq_pkg::entry_t prev_entry;
            ssq_pkg::entry_t next_entry;

            assign occupied = (OCC_W'(i) < occ_reg);

            if (i == 0)
            begin : g_first
                assign prev_open  = 1'b0;
                assign prev_entry = new_entry;
            end
            else
            begin : g_mid
                assign prev_open  = cell_open[i-1];
                assign prev_entry = cell_entry[i-1];
            end

            if (i == MAX_SLEEPERS - 1)
            begin : g_last
                assign next_entry = cell_entry[i];
            end
            else
            begin : g_next
                assign next_entry = cell_entry[i+1];
            end

            ssq_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied),
                .new_entry  (new_entry),
                .prev_open  (prev_open),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .open       (cell_open[i]),
                .entry      (cell_entry[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssq_pkg::ST_IDLE:
            begin
                if (accept && (operation == ssq_pkg::OP_TICK))
                begin
                    state_next = ssq_pkg::ST_WAKE;
                end
            end
            ssq_pkg::ST_WAKE:
            begin
                if (out_free && (!front_due || pop_last))
                begin
                    state_next = ssq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        tick_next      = tick_reg;
        occ_next       = occ_reg;
        pop_cnt_next   = pop_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        case (state_reg)
            ssq_pkg::ST_IDLE:
            begin
                if (accept && (operation == ssq_pkg::OP_SLEEP))
                begin
                    out_valid_next = 1'b1;
                    id_next        = '0;
                    now_next       = tick_reg;
                    last_next      = 1'b1;
                    if (!dur_positive)
                    begin
                        kind_next = ssq_pkg::KIND_IGNORED;
                    end
                    else if (full)
                    begin
                        kind_next = ssq_pkg::KIND_REJECTED;
                    end
                    else
                    begin
                        kind_next   = ssq_pkg::KIND_QUEUED;
                        ctrl.insert = 1'b1;
                        occ_next    = occ_reg + OCC_W'(1);
                    end
                end
                else if (accept)
                begin
                    tick_next    = tick_reg + ssq_pkg::TICK_W'(1);
                    pop_cnt_next = '0;
                end
            end
            ssq_pkg::ST_WAKE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    now_next       = tick_reg;
                    if (front_due)
                    begin
                        kind_next    = ssq_pkg::KIND_WOKEN;
                        id_next      = cell_entry[0].id;
                        last_next    = pop_last;
                        ctrl.pop     = 1'b1;
                        occ_next     = occ_reg - OCC_W'(1);
                        pop_cnt_next = pop_cnt_reg + ssq_pkg::POP_W'(1);
                    end
                    else
                    begin
                        kind_next = ssq_pkg::KIND_NONE_DUE;
                        id_next   = '0;
                        last_next = 1'b1;
                    end
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssq_pkg::ST_IDLE;
            tick_reg      <= '0;
            occ_reg       <= '0;
            pop_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            occ_reg       <= occ_next;
            pop_cnt_reg   <= pop_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        now_reg  <= now_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign woken_id  = id_reg;
    assign now_tick  = now_reg;
    assign last      = last_reg;

    a_no_insert_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.insert && ctrl.pop))
        else $error("insert and pop in the same cycle");

    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |-> (occ_reg < OCC_W'(MAX_SLEEPERS)))
        else $error("insert into a full chain");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (occ_reg != '0))
        else $error("pop from an empty chain");

    a_tick_enters_wake: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == ssq_pkg::OP_TICK))
        |=> ((state_reg == ssq_pkg::ST_WAKE) && (tick_reg == $past(tick_reg) + 1'b1)))
        else $error("tick transaction did not advance the counter");

endmodule

// ===== tb/sorted_sleep_wake_queue_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sleep_wake_queue_unit_checker
// Watches both channels of the sleep queue, works out the results of every
// accepted request and tick from its own copy of the tick counter and the
// sorted sleeper list, and compares each delivered result field by field
// with the oldest one still awaited.
// ----------------------------------------------------------------------------
module sorted_sleep_wake_queue_unit_checker
#(
    parameter int MAX_SLEEPERS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                operation,
    input  logic [ssq_pkg::ID_W-1:0]            thread_id,
    input  logic signed [ssq_pkg::DUR_W-1:0]    duration,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [2:0]                          kind,
    input  logic [ssq_pkg::ID_W-1:0]            woken_id,
    input  logic [ssq_pkg::TICK_W-1:0]          now_tick,
    input  logic                                last,
    output int                                  errors,
    output int                                  pending
);

    typedef struct packed {
        logic [ssq_pkg::KEY_W-1:0] wake_at;
        logic [ssq_pkg::ID_W-1:0]  id;
    } sleeper_t;

    typedef struct packed {
        ssq_pkg::kind_t             kind;
        logic [ssq_pkg::ID_W-1:0]   id;
        logic [ssq_pkg::TICK_W-1:0] tick;
        logic                       last;
    } wake_result_t;

    sleeper_t                   sleepers[$];
    wake_result_t               awaited[$];
    logic [ssq_pkg::TICK_W-1:0] tick_now = '0;
    int                         mismatches = 0;

    task automatic note_mismatch(input string what,
                                 input logic [ssq_pkg::KEY_W-1:0] got,
                                 input logic [ssq_pkg::KEY_W-1:0] want);
        mismatches++;
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic void queue_result(ssq_pkg::kind_t k,
                                         logic [ssq_pkg::ID_W-1:0] id, logic fin);
        wake_result_t r;
        r.kind = k;
        r.id   = id;
        r.tick = tick_now;
        r.last = fin;
        awaited.push_back(r);
    endfunction

    function automatic void predict_transaction(logic op, logic [ssq_pkg::ID_W-1:0] id,
                                                logic [ssq_pkg::DUR_W-1:0] dur);
        sleeper_t s;
        int       pos;
        int       due;
        if (op == ssq_pkg::OP_SLEEP)
        begin
            if (dur == '0 || dur[ssq_pkg::DUR_W-1])
                queue_result(ssq_pkg::KIND_IGNORED, '0, 1'b1);
            else if (sleepers.size() >= MAX_SLEEPERS)
                queue_result(ssq_pkg::KIND_REJECTED, '0, 1'b1);
            else
            begin
                s.wake_at = {1'b0, tick_now} + ssq_pkg::KEY_W'(dur);
                s.id      = id;
                pos       = sleepers.size();
                // Equal wake ticks go behind the ones already queued.
                for (int i = sleepers.size() - 1; i >= 0; i--)
                    if (sleepers[i].wake_at > s.wake_at)
                        pos = i;
                sleepers.insert(pos, s);
                queue_result(ssq_pkg::KIND_QUEUED, '0, 1'b1);
            end
        end
        else
        begin
            tick_now = tick_now + ssq_pkg::TICK_W'(1);
            due = 0;
            while (due < sleepers.size() && due < ssq_pkg::RESULT_CAP &&
                   sleepers[due].wake_at <= {1'b0, tick_now})
                due++;
            if (due == 0)
                queue_result(ssq_pkg::KIND_NONE_DUE, '0, 1'b1);
            for (int i = 0; i < due; i++)
            begin
                queue_result(ssq_pkg::KIND_WOKEN, sleepers[0].id, i == due - 1);
                sleepers.delete(0);
            end
        end
    endfunction

    always @(posedge clk)
    begin : watch
        wake_result_t want;
        if (!rst_n)
        begin
            sleepers.delete();
            awaited.delete();
            tick_now = '0;
        end
        else
        begin
            // A result transaction is compared before a new input transaction
            // of the same edge adds its own expectations.
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                    note_mismatch("result with nothing awaited",
                                  ssq_pkg::KEY_W'({kind, woken_id}), '0);
                else
                begin
                    want = awaited.pop_front();
                    if (kind !== want.kind)
                        note_mismatch("kind", ssq_pkg::KEY_W'(kind),
                                      ssq_pkg::KEY_W'(want.kind));
                    if (woken_id !== want.id)
                        note_mismatch("woken_id", ssq_pkg::KEY_W'(woken_id),
                                      ssq_pkg::KEY_W'(want.id));
                    if (now_tick !== want.tick)
                        note_mismatch("now_tick", ssq_pkg::KEY_W'(now_tick),
                                      ssq_pkg::KEY_W'(want.tick));
                    if (last !== want.last)
                        note_mismatch("last", ssq_pkg::KEY_W'(last),
                                      ssq_pkg::KEY_W'(want.last));
                end
            end
            if (in_valid && !in_stall)
                predict_transaction(operation, thread_id, duration);
        end
        errors  <= mismatches;
        pending <= awaited.size();
    end

endmodule

// ===== tb/sorted_sleep_wake_queue_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sleep_wake_queue_unit_test
// Drives sleep requests and timer ticks into the sleep queue with random
// gaps and output stalls: a directed opening covers equal wake ticks, the
// extremes of the duration, ignored and rejected requests and a tick that
// wakes a nearly full queue at once, then random traffic follows. A separate
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_sleep_wake_queue_unit_test;

    localparam int MAX_SLEEPERS = 16;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              operation = ssq_pkg::OP_TICK;
    logic [ssq_pkg::ID_W-1:0]          thread_id = '0;
    logic signed [ssq_pkg::DUR_W-1:0]  duration = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [2:0]                        kind;
    logic [ssq_pkg::ID_W-1:0]          woken_id;
    logic [ssq_pkg::TICK_W-1:0]        now_tick;
    logic                              last;
    int                                errors;
    int                                pending;
    bit                                calm = 1'b0;

    always #5 clk = ~clk;

    sorted_sleep_wake_queue_unit #(.MAX_SLEEPERS(MAX_SLEEPERS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .thread_id (thread_id),
        .duration  (duration),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .woken_id  (woken_id),
        .now_tick  (now_tick),
        .last      (last)
    );

    sorted_sleep_wake_queue_unit_checker #(.MAX_SLEEPERS(MAX_SLEEPERS)) audit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .thread_id (thread_id),
        .duration  (duration),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .woken_id  (woken_id),
        .now_tick  (now_tick),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    function automatic int idle_cycles();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_request(input ssq_pkg::op_t op,
                                input logic [ssq_pkg::ID_W-1:0] id,
                                input logic [ssq_pkg::DUR_W-1:0] dur);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        thread_id <= id;
        duration  <= dur;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = idle_cycles();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        int r;
        int k;
        int d;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ssq_pkg::OP_SLEEP, 8'h00, 32'd1);
        send_request(ssq_pkg::OP_SLEEP, 8'hFF, 32'd1);
        send_request(ssq_pkg::OP_SLEEP, 8'h07, 32'd2);
        send_request(ssq_pkg::OP_SLEEP, 8'h09, 32'd0);
        send_request(ssq_pkg::OP_SLEEP, 8'h0A, 32'hFFFF_FFFF);
        send_request(ssq_pkg::OP_SLEEP, 8'h0B, 32'h8000_0000);
        send_request(ssq_pkg::OP_SLEEP, 8'h0C, 32'h7FFF_FFFF);
        repeat (3) send_request(ssq_pkg::OP_TICK, ssq_pkg::ID_W'($urandom), $urandom);
        // The queue fills up, the last request is turned away, and the third
        // tick then wakes every sleeper of the same wake tick in one go.
        for (int i = 0; i < MAX_SLEEPERS; i++)
            send_request(ssq_pkg::OP_SLEEP, ssq_pkg::ID_W'(16 + i), 32'd3);
        repeat (3) send_request(ssq_pkg::OP_TICK, ssq_pkg::ID_W'($urandom), $urandom);

        for (int n = 0; n < 190; n++)
        begin
            calm = (n >= 100 && n < 140);
            if (n == 180)
                wait_for_results();
            r = $urandom_range(0, 99);
            if (r < 42)
                send_request(ssq_pkg::OP_TICK, ssq_pkg::ID_W'($urandom), $urandom);
            else if (r < 50)
                send_request(ssq_pkg::OP_SLEEP, ssq_pkg::ID_W'($urandom),
                             r[0] ? 32'd0 : {1'b1, 31'($urandom)});
            else if (r < 54)
            begin
                k = $urandom_range(3, 8);
                d = $urandom_range(1, 6);
                repeat (k) send_request(ssq_pkg::OP_SLEEP, ssq_pkg::ID_W'($urandom), d);
            end
            else
                send_request(ssq_pkg::OP_SLEEP, ssq_pkg::ID_W'($urandom),
                             $urandom_range(1, r < 57 ? 300 : 24));
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("sorted_sleep_wake_queue_unit_test: clean");
        else
            $display("sorted_sleep_wake_queue_unit_test: errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("sorted_sleep_wake_queue_unit_test: errors");
        $finish;
    end

endmodule
